// File: src/xcrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcrd_pkg: shared types and codes of the character reference decoder
// Holds the error codes and the result group that the decoder hands to the
// output stage.
// ----------------------------------------------------------------------------
package xcrd_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_MALFORMED    = 3'd1;
    localparam logic [2:0] ERR_RANGE        = 3'd2;
    localparam logic [2:0] ERR_INVALID      = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN      = 3'd5;

    // The results that one input item causes, first result in entry 0.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic [2:0]                  err;
    } group_t;

endpackage
`default_nettype wire

// File: src/xcrd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcrd_decode: reference parser and UTF-8 encoder
// Holds the parse state and works out, for the presented item, the group of
// results it causes. The state moves on when step is high.
// ----------------------------------------------------------------------------
module xcrd_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      in_byte,
    input  wire logic            input_ended,
    output xcrd_pkg::group_t     grp
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_AMP,
        PH_HASH,
        PH_NUM,
        PH_NAME
    } phase_t;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [24:0] CP_MAX  = 25'h10FFFF;

    phase_t           phase_reg, phase_next;
    logic             hex_reg, hex_next;
    logic [20:0]      cp_reg, cp_next;
    logic             seen_reg, seen_next;
    logic [3:0][7:0]  name_reg, name_next;
    logic [2:0]       len_reg, len_next;

    logic             is_dec, is_hex_lo, is_hex_up, digit_ok, range_err;
    logic [3:0]       dval;
    logic [24:0]      prod, sum;

    function automatic logic name_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               c == 8'h5F || c == 8'h3A || c[7] ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E;
    endfunction

    function automatic xcrd_pkg::group_t one(input logic [7:0] b,
                                             input logic [2:0] e);
        xcrd_pkg::group_t g;
        g       = '0;
        g.bytes[0] = b;
        g.count = xcrd_pkg::CNT_W'(1);
        g.err   = e;
        return g;
    endfunction

    function automatic xcrd_pkg::group_t utf8(input logic [20:0] cp);
        xcrd_pkg::group_t g;
        g = '0;
        if (cp <= 21'h7F) begin
            g.bytes[0] = cp[7:0];
            g.count    = xcrd_pkg::CNT_W'(1);
        end else if (cp <= 21'h7FF) begin
            g.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            g.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            g.count    = xcrd_pkg::CNT_W'(2);
        end else if (cp <= 21'hFFFF) begin
            g.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            g.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            g.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            g.count    = xcrd_pkg::CNT_W'(3);
        end else begin
            g.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
            g.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            g.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            g.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            g.count    = xcrd_pkg::CNT_W'(4);
        end
        return g;
    endfunction

    // Digit value and the shift-and-add step of the accumulator.
    always_comb
    begin
        is_dec    = in_byte >= 8'h30 && in_byte <= 8'h39;
        is_hex_lo = hex_reg && in_byte >= 8'h61 && in_byte <= 8'h66;
        is_hex_up = hex_reg && in_byte >= 8'h41 && in_byte <= 8'h46;
        digit_ok  = is_dec || is_hex_lo || is_hex_up;
        if (is_dec)
            dval = in_byte[3:0];
        else
            dval = in_byte[3:0] + 4'd9;
        if (hex_reg)
            prod = {cp_reg, 4'b0000};
        else
            prod = {1'b0, cp_reg, 3'b000} + {3'b000, cp_reg, 1'b0};
        sum       = prod + {21'd0, dval};
        range_err = sum > CP_MAX;
    end

    always_comb
    begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        cp_next    = cp_reg;
        seen_next  = seen_reg;
        name_next  = name_reg;
        len_next   = len_reg;
        grp        = '0;

        if (input_ended) begin
            unique case (phase_reg)
                PH_HASH, PH_NUM: grp = one(8'h00, xcrd_pkg::ERR_MALFORMED);
                PH_AMP, PH_NAME: grp = one(8'h00, xcrd_pkg::ERR_UNTERMINATED);
                default:         grp = '0;
            endcase
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_AMP, PH_NAME:
                begin
                    if (phase_reg == PH_AMP && in_byte == CH_HASH) begin
                        phase_next = PH_HASH;
                    end else if (in_byte == CH_SEMI) begin
                        phase_next = PH_IDLE;
                        if (len_reg == 3'd2 && name_reg[0] == 8'h6C &&
                            name_reg[1] == 8'h74)
                            grp = one(CH_LT, xcrd_pkg::ERR_NONE);
                        else if (len_reg == 3'd2 && name_reg[0] == 8'h67 &&
                                 name_reg[1] == 8'h74)
                            grp = one(CH_GT, xcrd_pkg::ERR_NONE);
                        else if (len_reg == 3'd3 && name_reg[0] == 8'h61 &&
                                 name_reg[1] == 8'h6D && name_reg[2] == 8'h70)
                            grp = one(CH_AMP, xcrd_pkg::ERR_NONE);
                        else if (len_reg == 3'd4 && name_reg[0] == 8'h61 &&
                                 name_reg[1] == 8'h70 && name_reg[2] == 8'h6F &&
                                 name_reg[3] == 8'h73)
                            grp = one(CH_APOS, xcrd_pkg::ERR_NONE);
                        else if (len_reg == 3'd4 && name_reg[0] == 8'h71 &&
                                 name_reg[1] == 8'h75 && name_reg[2] == 8'h6F &&
                                 name_reg[3] == 8'h74)
                            grp = one(CH_QUOT, xcrd_pkg::ERR_NONE);
                        else
                            grp = one(8'h00, xcrd_pkg::ERR_UNKNOWN);
                    end else if (!name_char(in_byte)) begin
                        phase_next = PH_IDLE;
                        grp        = one(8'h00, xcrd_pkg::ERR_UNTERMINATED);
                    end else begin
                        // Only four name bytes are kept; the length saturates at
                        // five so that longer names never match.
                        if (len_reg < 3'd4)
                            name_next[len_reg[1:0]] = in_byte;
                        if (len_reg < 3'd5)
                            len_next = len_reg + 3'd1;
                        phase_next = PH_NAME;
                    end
                end
                PH_HASH, PH_NUM:
                begin
                    if (phase_reg == PH_HASH &&
                        (in_byte == CH_X_LO || in_byte == CH_X_UP)) begin
                        hex_next   = 1'b1;
                        phase_next = PH_NUM;
                    end else if (in_byte == CH_SEMI) begin
                        phase_next = PH_IDLE;
                        if (!seen_reg)
                            grp = one(8'h00, xcrd_pkg::ERR_MALFORMED);
                        else if (cp_reg >= 21'hD800 && cp_reg <= 21'hDFFF)
                            grp = one(8'h00, xcrd_pkg::ERR_INVALID);
                        else
                            grp = utf8(cp_reg);
                    end else if (!digit_ok) begin
                        phase_next = PH_IDLE;
                        grp        = one(8'h00, xcrd_pkg::ERR_MALFORMED);
                    end else if (range_err) begin
                        phase_next = PH_IDLE;
                        grp        = one(8'h00, xcrd_pkg::ERR_RANGE);
                    end else begin
                        cp_next    = sum[20:0];
                        seen_next  = 1'b1;
                        phase_next = PH_NUM;
                    end
                end
                default:
                begin
                    phase_next = (in_byte == CH_AMP) ? PH_AMP : PH_IDLE;
                end
            endcase
        end

        // Every return to idle restores the reset values.
        if (phase_next == PH_IDLE) begin
            hex_next  = 1'b0;
            cp_next   = '0;
            seen_next = 1'b0;
            name_next = '0;
            len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            hex_reg   <= 1'b0;
            cp_reg    <= '0;
            seen_reg  <= 1'b0;
            name_reg  <= '0;
            len_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            cp_reg    <= cp_next;
            seen_reg  <= seen_next;
            name_reg  <= name_next;
            len_reg   <= len_next;
        end
    end

endmodule
`default_nettype wire

// File: src/xml_char_reference_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item waits in the input register until it is decoded; its result
// group, if any, then goes to the output register, which raises out_valid.
// Throughput: one item per cycle while out_ready stays high; a reference that
// yields several results holds the decode step while its result group drains.
// Reset clears the valid flags, the result index and all parse state to idle.
// ----------------------------------------------------------------------------
// xml_char_reference_decoder: XML character and entity reference decoder
// Turns numeric and predefined named references in a byte stream into UTF-8
// bytes, reporting malformed or unknown references as single error results.
// ----------------------------------------------------------------------------
module xml_char_reference_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       input_ended,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic [2:0]      error_code
);

    // The input register holds one item. It is decoded when the result group
    // register is empty or hands over its final result in the same cycle, so
    // the two sides never wait on each other longer than the group takes.
    logic                        in_valid_reg;
    logic [7:0]                  byte_reg;
    logic                        ended_reg;

    // The result group register keeps every result of one item; idx_reg
    // points at the result currently presented on the output port.
    xcrd_pkg::group_t            grp_reg;
    logic                        grp_valid_reg, grp_valid_next;
    logic [xcrd_pkg::IDX_W-1:0]  idx_reg, idx_next;

    xcrd_pkg::group_t            dec_grp;
    logic                        finishing;
    logic                        advance;

    xcrd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .in_byte     (byte_reg),
        .input_ended (ended_reg),
        .grp         (dec_grp)
    );

    assign out_valid  = grp_valid_reg;
    assign out_byte   = grp_reg.bytes[idx_reg];
    assign error_code = grp_reg.err;
    assign last       = (xcrd_pkg::CNT_W'(idx_reg) == grp_reg.count - xcrd_pkg::CNT_W'(1));

    assign finishing  = grp_valid_reg && out_ready && last;
    assign advance    = in_valid_reg && (!grp_valid_reg || finishing);
    assign in_ready   = !in_valid_reg || advance;

    // Next state of the output side: step through the group on each taken
    // result, then load the next group when the decoder moves on.
    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        if (grp_valid_reg && out_ready) begin
            if (last)
                grp_valid_next = 1'b0;
            else
                idx_next = idx_reg + xcrd_pkg::IDX_W'(1);
        end
        if (advance && dec_grp.count != '0) begin
            grp_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (in_ready)
                in_valid_reg <= in_valid;
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg  <= in_byte;
            ended_reg <= input_ended;
        end
        if (advance && dec_grp.count != '0)
            grp_reg <= dec_grp;
    end

    // A presented group always holds between one and four results.
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (grp_reg.count != '0 &&
                           grp_reg.count <= xcrd_pkg::CNT_W'(xcrd_pkg::MAX_RESULTS)))
        else $error("result group count out of range");

    // The result index never runs past the end of its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (xcrd_pkg::CNT_W'(idx_reg) < grp_reg.count))
        else $error("result index beyond group");

    // An error result is a single result with a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && error_code != xcrd_pkg::ERR_NONE) |-> (last && out_byte == 8'h00))
        else $error("error result not single or not zero");

    // A result still waiting to be taken keeps its position in the group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && !out_ready) |=> (grp_valid_reg && $stable(idx_reg)))
        else $error("stalled result moved");

    // The decoder never steps while a non-final result is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && !last) |-> !advance)
        else $error("decode stepped over pending results");

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream test of the XML character reference decoder
// Feeds byte streams into the decoder: a short directed stream with the corner
// cases first, then random references, most of them well formed. A scoreboard
// decodes every accepted item on its own and checks each result byte, last flag
// and error code in order. Handshakes stall at random except in the last third.
// ----------------------------------------------------------------------------
module testbench;

    // Sequence bytes wanted in the random part; noise bytes do not count.
    localparam int RANDOM_ITEMS = 195;
    // Cycles with no handshake on either side before the run is abandoned.
    localparam int QUIET_LIMIT  = 1000;
    // Cycles allowed after the last expected result for stray results.
    localparam int DRAIN_CYCLES = 8;

    // Parser phases of the decoder.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMP,
        ST_HASH,
        ST_NUM,
        ST_NAME
    } parse_state_t;

    // One result item as the decoder should present it.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [2:0] err;
    } utf8_result_t;

    // One input item of the byte stream.
    typedef struct {
        logic [7:0] data;
        logic       ended;
    } stream_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: decodes each accepted byte into the results it must cause
    // and checks the results that the decoder delivers against them.
    // ------------------------------------------------------------------------
    class utf8_scoreboard;
        utf8_result_t expected_utf8[$];
        int           mismatches;

        parse_state_t state;
        bit           hex;
        logic [20:0]  cp;
        bit           seen;
        logic [31:0]  name_word;   // first name byte in the top byte
        logic [2:0]   name_len;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            state     = ST_IDLE;
            hex       = 1'b0;
            cp        = '0;
            seen      = 1'b0;
            name_word = '0;
            name_len  = '0;
        endfunction

        function void add(logic [7:0] data, logic lst, logic [2:0] err);
            utf8_result_t r;
            r.data = data;
            r.last = lst;
            r.err  = err;
            expected_utf8.insert(expected_utf8.size(), r);
        endfunction

        function void reject(logic [2:0] err);
            add(8'h00, 1'b1, err);
            clear();
        endfunction

        function bit valid_name_byte(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_" ||
                   c == ":" || c >= 8'h80 || (c >= "0" && c <= "9") || c == "-" ||
                   c == ".";
        endfunction

        function void emit_utf8(logic [20:0] value);
            if (value > 21'h10FFFF || (value >= 21'h00D800 && value <= 21'h00DFFF))
            begin
                reject(xcrd_pkg::ERR_INVALID);
                return;
            end
            if (value <= 21'h7F)
                add(value[7:0], 1'b1, xcrd_pkg::ERR_NONE);
            else if (value <= 21'h7FF)
            begin
                add(8'hC0 | {3'b000, value[10:6]}, 1'b0, xcrd_pkg::ERR_NONE);
                add(8'h80 | {2'b00, value[5:0]}, 1'b1, xcrd_pkg::ERR_NONE);
            end
            else if (value <= 21'hFFFF)
            begin
                add(8'hE0 | {4'b0000, value[15:12]}, 1'b0, xcrd_pkg::ERR_NONE);
                add(8'h80 | {2'b00, value[11:6]}, 1'b0, xcrd_pkg::ERR_NONE);
                add(8'h80 | {2'b00, value[5:0]}, 1'b1, xcrd_pkg::ERR_NONE);
            end
            else
            begin
                add(8'hF0 | {5'b00000, value[20:18]}, 1'b0, xcrd_pkg::ERR_NONE);
                add(8'h80 | {2'b00, value[17:12]}, 1'b0, xcrd_pkg::ERR_NONE);
                add(8'h80 | {2'b00, value[11:6]}, 1'b0, xcrd_pkg::ERR_NONE);
                add(8'h80 | {2'b00, value[5:0]}, 1'b1, xcrd_pkg::ERR_NONE);
            end
            clear();
        endfunction

        function void take_digit(logic [7:0] c);
            logic [31:0] v;
            logic [31:0] nxt;
            if (c >= "0" && c <= "9")
                v = {24'h0, 8'(c - "0")};
            else if (hex && c >= "a" && c <= "f")
                v = {24'h0, 8'(c - "a" + 8'd10)};
            else if (hex && c >= "A" && c <= "F")
                v = {24'h0, 8'(c - "A" + 8'd10)};
            else
            begin
                reject(xcrd_pkg::ERR_MALFORMED);
                return;
            end
            nxt = {11'b0, cp} * (hex ? 32'd16 : 32'd10) + v;
            // The range check fires on the digit that pushes the value over.
            if (nxt > 32'h10FFFF)
                reject(xcrd_pkg::ERR_RANGE);
            else
            begin
                cp   = nxt[20:0];
                seen = 1'b1;
            end
        endfunction

        function void take_name(logic [7:0] c);
            if (c == ";")
            begin
                // Unused name bytes stay zero, so the length and the packed
                // word together identify the name.
                if (name_len == 3'd2 && name_word == {"lt", 16'h0})
                    add("<", 1'b1, xcrd_pkg::ERR_NONE);
                else if (name_len == 3'd2 && name_word == {"gt", 16'h0})
                    add(">", 1'b1, xcrd_pkg::ERR_NONE);
                else if (name_len == 3'd3 && name_word == {"amp", 8'h0})
                    add("&", 1'b1, xcrd_pkg::ERR_NONE);
                else if (name_len == 3'd4 && name_word == "apos")
                    add("'", 1'b1, xcrd_pkg::ERR_NONE);
                else if (name_len == 3'd4 && name_word == "quot")
                    add("\"", 1'b1, xcrd_pkg::ERR_NONE);
                else
                begin
                    reject(xcrd_pkg::ERR_UNKNOWN);
                    return;
                end
                clear();
                return;
            end
            if (!valid_name_byte(c))
            begin
                reject(xcrd_pkg::ERR_UNTERMINATED);
                return;
            end
            if (name_len < 3'd4)
                name_word[31 - 8 * name_len -: 8] = c;
            if (name_len < 3'd5)
                name_len = name_len + 3'd1;
            state = ST_NAME;
        endfunction

        // Works out the results of one accepted input item.
        function void note_byte(logic [7:0] c, logic ended);
            if (ended)
            begin
                case (state)
                    ST_HASH, ST_NUM: reject(xcrd_pkg::ERR_MALFORMED);
                    ST_AMP, ST_NAME: reject(xcrd_pkg::ERR_UNTERMINATED);
                    default:         clear();
                endcase
                return;
            end
            case (state)
                ST_AMP:
                begin
                    if (c == "#")
                        state = ST_HASH;
                    else
                        take_name(c);
                end
                ST_HASH:
                begin
                    if (c == "x" || c == "X")
                    begin
                        hex   = 1'b1;
                        state = ST_NUM;
                    end
                    else
                    begin
                        state = ST_NUM;
                        if (c == ";")
                            reject(xcrd_pkg::ERR_MALFORMED);
                        else
                            take_digit(c);
                    end
                end
                ST_NUM:
                begin
                    if (c == ";")
                    begin
                        if (!seen)
                            reject(xcrd_pkg::ERR_MALFORMED);
                        else
                            emit_utf8(cp);
                    end
                    else
                        take_digit(c);
                end
                ST_NAME:
                    take_name(c);
                default:
                begin
                    clear();
                    if (c == "&")
                        state = ST_AMP;
                end
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // Compares one accepted result item with the oldest expectation.
        function void check_out(logic [7:0] data, logic lst, logic [2:0] err);
            utf8_result_t want;
            if (expected_utf8.size() == 0)
            begin
                flag($sformatf("unexpected result: byte=%02h last=%0b error=%0d",
                               data, lst, err));
                return;
            end
            want = expected_utf8.pop_front();
            if (data !== want.data || lst !== want.last || err !== want.err)
                flag($sformatf({"result mismatch: expected byte=%02h last=%0b error=%0d,",
                                " got byte=%02h last=%0b error=%0d"},
                               want.data, want.last, want.err, data, lst, err));
        endfunction

        function int pending();
            return expected_utf8.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its signals. Every input has a known value from
    // time zero on.
    // ------------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       input_ended = 1'b0;
    logic       out_ready   = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] error_code;

    xml_char_reference_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .input_ended (input_ended),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last),
        .error_code  (error_code)
    );

    utf8_scoreboard sb;
    stream_item_t   stream_q[$];
    int             sequence_items = 0;

    // Idle rates in percent; the main sequence changes them as the run goes
    // through its three phases.
    int send_gap_pct   = 28;
    int recv_stall_pct = 54;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Stream building. Bytes that belong to references count toward the size
    // of the random part; noise bytes are queued directly and do not.
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] data);
        stream_q.insert(stream_q.size(), stream_item_t'{data: data, ended: 1'b0});
        sequence_items++;
    endtask

    // The end of the stream; the byte that comes with it is random, since the
    // decoder must ignore it.
    task automatic push_end();
        stream_q.insert(stream_q.size(),
                        stream_item_t'{data: 8'($urandom_range(0, 255)), ended: 1'b1});
        sequence_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s.getc(i));
    endtask

    // Code points drawn from every UTF-8 length, the boundaries between them,
    // the surrogate block and values past the top of the code space.
    function automatic int unsigned random_code_point();
        int unsigned edges[10] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800,
                                   32'hD7FF, 32'hE000, 32'hFFFF, 32'h10000,
                                   32'h10FFFF};
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 32'h7F);
            1:       return $urandom_range(32'h80, 32'h7FF);
            2:       return $urandom_range(32'h800, 32'hFFFF);
            3:       return $urandom_range(32'h10000, 32'h10FFFF);
            4, 5:    return edges[$urandom_range(0, 9)];
            6:       return $urandom_range(32'hD800, 32'hDFFF);
            7:       return $urandom_range(32'h110000, 32'hFFFFFF);
            default: return $urandom_range(0, 32'h10FFFF);
        endcase
    endfunction

    // A numeric reference in decimal or hex, with mixed case hex digits and
    // sometimes leading zeros.
    function automatic string numeric_ref(input int unsigned value, input bit as_hex);
        string digits;
        string mark;
        byte   ch;
        mark = "";
        if (as_hex)
        begin
            digits = $sformatf("%0h", value);
            mark   = $urandom_range(0, 1) ? "X" : "x";
            for (int i = 0; i < digits.len(); i++)
            begin
                ch = digits.getc(i);
                if (ch >= "a" && $urandom_range(0, 1))
                    digits.putc(i, ch - 8'd32);
            end
        end
        else
            digits = $sformatf("%0d", value);
        if ($urandom_range(0, 7) == 0)
            digits = {"00", digits};
        return {"&#", mark, digits, ";"};
    endfunction

    function automatic logic [7:0] random_name_char();
        string punct;
        punct = "_:-.";
        case ($urandom_range(0, 5))
            0, 1:    return 8'($urandom_range(8'h61, 8'h7A));
            2:       return 8'($urandom_range(8'h41, 8'h5A));
            3:       return 8'($urandom_range(8'h30, 8'h39));
            4:       return punct.getc($urandom_range(0, 3));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    // Half of the named references are the predefined ones, the rest random
    // names of up to six bytes, the empty name among them.
    function automatic string named_ref();
        string known[5] = '{"lt", "gt", "amp", "apos", "quot"};
        string name;
        if ($urandom_range(0, 1))
            name = known[$urandom_range(0, 4)];
        else
        begin
            name = "";
            repeat ($urandom_range(0, 6))
                name = $sformatf("%s%c", name, random_name_char());
        end
        return {"&", name, ";"};
    endfunction

    // ------------------------------------------------------------------------
    // Driving. An item is held on the inputs until the edge that accepts it,
    // and the scoreboard learns of it at that same edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input stream_item_t item);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= item.data;
        input_ended <= item.ended;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(item.data, item.ended);
    endtask

    // The receiver checks each accepted result and picks its next ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_out(out_byte, last, error_code);
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // The watchdog ends the run when neither side has moved an item for too
    // long, which a correct decoder never causes.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int    pick;
        int    total;
        string txt;

        sb = new();

        // Directed part. Extreme byte values in idle, code point zero, the
        // empty name, an empty digit string, a bad hex digit followed at once
        // by a new reference whose name holds a high byte and then a non-name
        // byte, a predefined name, the end right after an ampersand and the
        // end while idle.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("&#0;");
        push_text("&;");
        push_text("&#;");
        push_text("&#xG");
        push_text("&q");
        push_byte(8'hFF);
        push_text("!");
        push_text("&gt;");
        push_text("&");
        push_end();
        push_end();

        // Random part: mostly well-formed references with random content,
        // mixed at random with cut-off references and noise.
        sequence_items = 0;
        while (sequence_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                push_text(numeric_ref(random_code_point(), $urandom_range(0, 1)));
            else if (pick < 72)
                push_text(named_ref());
            else if (pick < 86)
            begin
                if ($urandom_range(0, 1))
                    txt = numeric_ref(random_code_point(), $urandom_range(0, 1));
                else
                    txt = named_ref();
                push_text(txt.substr(0, $urandom_range(0, txt.len() - 2)));
                if ($urandom_range(0, 1))
                    push_end();
                else
                    push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    stream_q.insert(stream_q.size(),
                        stream_item_t'{data: 8'($urandom_range(0, 255)), ended: 1'b0});
                if ($urandom_range(0, 3) == 0)
                    stream_q.insert(stream_q.size(),
                        stream_item_t'{data: 8'($urandom_range(0, 255)), ended: 1'b1});
            end
        end

        // Reset is asserted once, at the start of the run.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first third runs with a slow receiver, the second with a slow
        // sender, the last with no idling at all.
        total = stream_q.size();
        foreach (stream_q[i])
        begin
            if (i == total / 3)
            begin
                send_gap_pct   = 54;
                recv_stall_pct = 28;
            end
            else if (i == (2 * total) / 3)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            send_item(stream_q[i]);
        end
        in_valid <= 1'b0;

        // Let every expected result arrive, then give a stray result time to
        // show up.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
